### design/dlmm_pkg.sv
package dlmm_pkg;

  localparam int VALUE_W = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 40;
  localparam int SUM_W   = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int LEN_W      = 7;
  localparam int CNT_W      = 5;

  localparam int DRAIN_CYCLES = 3;
  localparam int DRAIN_W      = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 1'b1;

  localparam logic signed [ACC_W-1:0] SUM_MAX_ACC = 40'sh00_7fff_ffff;
  localparam logic signed [ACC_W-1:0] SUM_MIN_ACC = 40'shff_8000_0000;
  localparam logic signed [SUM_W-1:0] SUM_MAX     = 32'sh7fff_ffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN     = 32'sh8000_0000;

  typedef struct packed {
    logic                      operation;
    logic [5:0]                weight_row;
    logic [3:0]                weight_col;
    logic signed [VALUE_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [3:0]              column;
    logic signed [SUM_W-1:0] sum;
    logic                    saturated;
    logic                    last;
  } out_rsp_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

### design/dlmm_ram.sv
module dlmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/dlmm_cell.sv
module dlmm_cell #(
  parameter int COL_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dlmm_pkg::cell_ctrl_t               ctrl,
  input  logic                               pkt_valid_i,
  input  logic [COL_W-1:0]                   pkt_tag_i,
  input  logic signed [dlmm_pkg::VALUE_W-1:0] pkt_value_i,
  input  logic signed [dlmm_pkg::VALUE_W-1:0] pkt_weight_i,
  output logic                               pkt_valid_o,
  output logic [COL_W-1:0]                   pkt_tag_o,
  output logic signed [dlmm_pkg::VALUE_W-1:0] pkt_value_o,
  output logic signed [dlmm_pkg::VALUE_W-1:0] pkt_weight_o,
  input  logic signed [dlmm_pkg::ACC_W-1:0]   acc_i,
  output logic signed [dlmm_pkg::ACC_W-1:0]   acc_o
);

  import dlmm_pkg::*;

  logic                      pkt_valid_r;
  logic [COL_W-1:0]          pkt_tag_r;
  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] weight_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic                      prod_vld_r;
  logic                      hit;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;

  assign hit      = pkt_valid_r && (pkt_tag_r == COL_W'(CELL_IDX));
  assign prod_nxt = value_r * weight_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.shift) begin
      acc_nxt = acc_i;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_valid_r <= 1'b0;
      prod_vld_r  <= 1'b0;
      acc_r       <= '0;
    end else begin
      pkt_valid_r <= pkt_valid_i;
      prod_vld_r  <= hit;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_tag_r <= pkt_tag_i;
    value_r   <= pkt_value_i;
    weight_r  <= pkt_weight_i;
    if (hit) begin
      prod_r <= prod_nxt;
    end
  end

  assign pkt_valid_o  = pkt_valid_r;
  assign pkt_tag_o    = pkt_tag_r;
  assign pkt_value_o  = value_r;
  assign pkt_weight_o = weight_r;
  assign acc_o        = acc_r;

endmodule

### design/dense_layer_matrix_multiply_unit.sv
// Dense-layer matrix multiply, signed Q8.8 in, saturated Q16.16 out. A weight request
// (operation 0) writes one weight into the weight memory; weights of rows or columns
// beyond the configured maximum are dropped. The weight memory has no reset and every
// weight a row touches must be written first. For a data request (operation 1), the
// single read port of the weight memory delivers one weight per cycle into a chain of
// MAX_COLUMNS cells, one per output column, each with its own multiplier and 40-bit
// accumulator, followed by a pipeline drain. The request that completes a row is
// followed by output_count results, one per column in column order with the last one
// marked, shifted out of the chain through an output register; the accumulators then
// clear. input_length and output_count are clamped to 1..MAX_INNER and 1..MAX_COLUMNS.
// Requests are taken one at a time.
module dense_layer_matrix_multiply_unit #(
  parameter int MAX_INNER   = 64,
  parameter int MAX_COLUMNS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dlmm_pkg::in_req_t                   in_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dlmm_pkg::out_rsp_t                  out_rsp,
  input  logic                                cfg_wr_en,
  input  logic [dlmm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [dlmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import dlmm_pkg::*;

  localparam int DEPTH  = MAX_INNER * MAX_COLUMNS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LEN_A  = $clog2(MAX_INNER + 1);
  localparam int LCMP_W = (LEN_A > LEN_W) ? LEN_A + 1 : LEN_W + 1;
  localparam int CNT_A  = $clog2(MAX_COLUMNS + 1);
  localparam int KCMP_W = (CNT_A > CNT_W) ? CNT_A + 1 : CNT_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_UNLOAD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0] len_r;
  logic [CNT_W-1:0] cnt_r;

  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [POS_W-1:0]          rd_pos_r;
  logic [COL_W-1:0]          rd_col_r, rd_col_nxt;
  logic [COL_W-1:0]          un_col_r, un_col_nxt;
  logic [COL_W-1:0]          last_col_r;
  logic                      row_done_r;
  logic [DRAIN_W-1:0]        drain_r, drain_nxt;
  logic signed [VALUE_W-1:0] value_r;
  logic                      rd_vld_r;
  logic [COL_W-1:0]          rd_tag_r;

  logic [LCMP_W-1:0] len_ext, eff_len, pos_plus;
  logic [KCMP_W-1:0] cnt_ext, eff_cnt;
  logic              row_done;
  logic              in_acc, data_acc, wr_ok;
  logic              rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic              can_load;

  logic       out_valid_r, out_valid_nxt;
  out_rsp_t   out_rsp_r, out_rsp_nxt;
  cell_ctrl_t ctrl;

  logic                      pkt_valid  [MAX_COLUMNS];
  logic [COL_W-1:0]          pkt_tag    [MAX_COLUMNS];
  logic signed [VALUE_W-1:0] pkt_value  [MAX_COLUMNS];
  logic signed [VALUE_W-1:0] pkt_weight [MAX_COLUMNS];
  logic signed [ACC_W-1:0]   acc        [MAX_COLUMNS];
  logic signed [ACC_W-1:0]   acc_head;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
      cnt_r <= CNT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx)
        CFG_INPUT_LENGTH: len_r <= cfg_data[LEN_W-1:0];
        CFG_OUTPUT_COUNT: cnt_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_ext = LCMP_W'(len_r);
  assign cnt_ext = KCMP_W'(cnt_r);

  always_comb begin
    if (len_ext == '0) begin
      eff_len = LCMP_W'(1);
    end else if (len_ext > LCMP_W'(MAX_INNER)) begin
      eff_len = LCMP_W'(MAX_INNER);
    end else begin
      eff_len = len_ext;
    end
    if (cnt_ext == '0) begin
      eff_cnt = KCMP_W'(1);
    end else if (cnt_ext > KCMP_W'(MAX_COLUMNS)) begin
      eff_cnt = KCMP_W'(MAX_COLUMNS);
    end else begin
      eff_cnt = cnt_ext;
    end
  end

  assign pos_plus = LCMP_W'(pos_r) + LCMP_W'(1);
  assign row_done = !(pos_plus < eff_len);
  assign pos_nxt  = row_done ? '0 : pos_plus[POS_W-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign data_acc = in_acc && (in_req.operation == OP_DATA);
  assign wr_ok    = in_acc && (in_req.operation == OP_WEIGHT)
                    && (32'(in_req.weight_row) < MAX_INNER)
                    && (32'(in_req.weight_col) < MAX_COLUMNS);

  assign wr_addr = AW'(in_req.weight_row) * AW'(MAX_COLUMNS) + AW'(in_req.weight_col);
  assign rd_addr = AW'(rd_pos_r) * AW'(MAX_COLUMNS) + AW'(rd_col_r);
  assign rd_en   = (state_r == ST_READ);

  dlmm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_weights (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (wr_addr),
    .wr_data (in_req.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign can_load = !out_valid_r || !out_stall;
  assign acc_head = acc[0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rd_col_nxt    = rd_col_r;
    un_col_nxt    = un_col_r;
    drain_nxt     = drain_r;
    ctrl          = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (data_acc) begin
          rd_col_nxt = COL_W'(MAX_COLUMNS - 1);
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_col_r == '0) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end else begin
          rd_col_nxt = rd_col_r - COL_W'(1);
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + DRAIN_W'(1);
        if (drain_r == DRAIN_W'(DRAIN_CYCLES - 1)) begin
          un_col_nxt = '0;
          state_nxt  = row_done_r ? ST_UNLOAD : ST_IDLE;
        end
      end
      ST_UNLOAD: begin
        if (can_load) begin
          out_valid_nxt      = 1'b1;
          out_rsp_nxt.column = 4'(un_col_r);
          out_rsp_nxt.last   = (un_col_r == last_col_r);
          if (acc_head > SUM_MAX_ACC) begin
            out_rsp_nxt.sum       = SUM_MAX;
            out_rsp_nxt.saturated = 1'b1;
          end else if (acc_head < SUM_MIN_ACC) begin
            out_rsp_nxt.sum       = SUM_MIN;
            out_rsp_nxt.saturated = 1'b1;
          end else begin
            out_rsp_nxt.sum       = acc_head[SUM_W-1:0];
            out_rsp_nxt.saturated = 1'b0;
          end
          if (un_col_r == last_col_r) begin
            ctrl.clear = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            ctrl.shift = 1'b1;
            un_col_nxt = un_col_r + COL_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      rd_col_r    <= '0;
      un_col_r    <= '0;
      drain_r     <= '0;
      rd_vld_r    <= 1'b0;
      row_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_col_r    <= rd_col_nxt;
      un_col_r    <= un_col_nxt;
      drain_r     <= drain_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
      if (data_acc) begin
        pos_r      <= pos_nxt;
        row_done_r <= row_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r  <= rd_col_r;
    out_rsp_r <= out_rsp_nxt;
    if (data_acc) begin
      value_r    <= in_req.value;
      rd_pos_r   <= pos_r;
      last_col_r <= COL_W'(eff_cnt - KCMP_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // cell chain
  assign pkt_valid[0]  = rd_vld_r;
  assign pkt_tag[0]    = rd_tag_r;
  assign pkt_value[0]  = value_r;
  assign pkt_weight[0] = signed'(rd_data);

  for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_cell
    if (k < MAX_COLUMNS - 1) begin : g_mid
      dlmm_cell #(
        .COL_W    (COL_W),
        .CELL_IDX (k)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .pkt_valid_i  (pkt_valid[k]),
        .pkt_tag_i    (pkt_tag[k]),
        .pkt_value_i  (pkt_value[k]),
        .pkt_weight_i (pkt_weight[k]),
        .pkt_valid_o  (pkt_valid[k+1]),
        .pkt_tag_o    (pkt_tag[k+1]),
        .pkt_value_o  (pkt_value[k+1]),
        .pkt_weight_o (pkt_weight[k+1]),
        .acc_i        (acc[k+1]),
        .acc_o        (acc[k])
      );
    end else begin : g_end
      dlmm_cell #(
        .COL_W    (COL_W),
        .CELL_IDX (k)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .pkt_valid_i  (pkt_valid[k]),
        .pkt_tag_i    (pkt_tag[k]),
        .pkt_value_i  (pkt_value[k]),
        .pkt_weight_i (pkt_weight[k]),
        .pkt_valid_o  (),
        .pkt_tag_o    (),
        .pkt_value_o  (),
        .pkt_weight_o (),
        .acc_i        ('0),
        .acc_o        (acc[k])
      );
    end
  end

  // checks
  a_unload_needs_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UNLOAD) |-> row_done_r)
    else $error("unload without a completed row");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |-> (out_valid_nxt && out_rsp_nxt.last))
    else $error("accumulator clear not paired with last result");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(pos_r) < MAX_INNER))
    else $error("row position beyond inner dimension");

  a_read_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && rd_col_r == '0) |=> (state_r == ST_DRAIN))
    else $error("weight read sweep did not end in drain");

endmodule

### tb/dense_layer_matrix_multiply_unit_tb.sv
module dense_layer_matrix_multiply_unit_tb;
  import dlmm_pkg::*;

  localparam int MAX_INNER   = 64;
  localparam int MAX_COLUMNS = 16;
  localparam int SETTLE      = 2 * (MAX_COLUMNS + 4) + DRAIN_CYCLES + 8;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES      = 9;

  // negative entries pick a random setting
  localparam int PHASE_LEN [PHASES] = '{1, 64, -1, 0, 5, 127, -1, 2, -1};
  localparam int PHASE_CNT [PHASES] = '{16, 1, -1, 31, 0, -1, 16, 17, -1};

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    in_req_t               req;
    bit                    has_sum;
    out_rsp_t              sum;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_req_t               in_req    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_rsp_t              out_rsp;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic signed [VALUE_W-1:0] weight_mirror [MAX_INNER][MAX_COLUMNS];
  bit                        weight_set [MAX_INNER][MAX_COLUMNS];
  logic signed [ACC_W-1:0]   col_acc [MAX_COLUMNS];
  int                        elem_pos;
  logic [LEN_W-1:0]          len_reg;
  logic [CNT_W-1:0]          cnt_reg;
  out_rsp_t                  sums_due [$];
  stim_row_t                 plan [$];
  int                        send_idle_pct = 0;
  int                        stall_pct = 0;
  int                        errors = 0;
  int                        quiet = 0;

  dense_layer_matrix_multiply_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = CFG_DATA_W'(data);
    return s;
  endfunction

  function automatic stim_row_t wt_row(input int row, input int col,
                                       input logic [VALUE_W-1:0] val);
    stim_row_t s;
    s = '{default: '0};
    s.req.operation  = OP_WEIGHT;
    s.req.weight_row = 6'(row);
    s.req.weight_col = 4'(col);
    s.req.value      = val;
    return s;
  endfunction

  function automatic stim_row_t dat_row(input logic [VALUE_W-1:0] val);
    stim_row_t s;
    s = '{default: '0};
    s.req.operation = OP_DATA;
    s.req.value     = val;
    return s;
  endfunction

  // single-column row completion with a hand-worked sum
  function automatic stim_row_t chk_row(input logic [VALUE_W-1:0] val,
                                        input logic [SUM_W-1:0] sum, input logic sat);
    stim_row_t s;
    s = dat_row(val);
    s.has_sum       = 1'b1;
    s.sum.column    = '0;
    s.sum.sum       = sum;
    s.sum.saturated = sat;
    s.sum.last      = 1'b1;
    return s;
  endfunction

  task automatic model_request(input in_req_t r, input bit keep);
    int                      len;
    int                      cnt;
    logic signed [ACC_W-1:0] prod;
    out_rsp_t                res;
    if (r.operation == OP_WEIGHT) begin
      weight_mirror[r.weight_row][r.weight_col] = r.value;
      weight_set[r.weight_row][r.weight_col]    = 1'b1;
    end else begin
      len = (len_reg == 0) ? 1 : (len_reg > MAX_INNER) ? MAX_INNER : int'(len_reg);
      for (int k = 0; k < MAX_COLUMNS; k++) begin
        prod       = $signed(r.value) * weight_mirror[elem_pos][k];
        col_acc[k] = col_acc[k] + prod;
      end
      if (elem_pos + 1 < len) begin
        elem_pos++;
      end else begin
        cnt = (cnt_reg == 0) ? 1 : (cnt_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cnt_reg);
        for (int k = 0; k < cnt; k++) begin
          res.column = 4'(k);
          if (col_acc[k] > SUM_MAX_ACC) begin
            res.sum       = SUM_MAX;
            res.saturated = 1'b1;
          end else if (col_acc[k] < SUM_MIN_ACC) begin
            res.sum       = SUM_MIN;
            res.saturated = 1'b1;
          end else begin
            res.sum       = col_acc[k][SUM_W-1:0];
            res.saturated = 1'b0;
          end
          res.last = (k == cnt - 1);
          if (keep) sums_due.push_back(res);
        end
        for (int k = 0; k < MAX_COLUMNS; k++) col_acc[k] = '0;
        elem_pos = 0;
      end
    end
  endtask

  task automatic push_req(input in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // weights of the row about to be read are written first if still unknown
  task automatic issue(input in_req_t r, input bit has_sum, input out_rsp_t sum);
    in_req_t fill;
    if (r.operation == OP_DATA) begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        if (!weight_set[elem_pos][c]) begin
          fill.operation  = OP_WEIGHT;
          fill.weight_row = elem_pos[5:0];
          fill.weight_col = 4'(c);
          fill.value      = rand_value();
          model_request(fill, 1'b1);
          push_req(fill);
        end
      end
    end
    model_request(r, !has_sum);
    if (has_sum) sums_due.push_back(sum);
    push_req(r);
  endtask

  task automatic drain_sums();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_sums();
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_INPUT_LENGTH) len_reg = data[LEN_W-1:0];
    else cnt_reg = data[CNT_W-1:0];
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sums_due.size() == 0) begin
        report_mismatch("sum with no request pending", out_rsp.sum, '0);
      end else begin
        want = sums_due.pop_front();
        if (out_rsp.column !== want.column)
          report_mismatch("column", 32'(out_rsp.column), 32'(want.column));
        if (out_rsp.sum !== want.sum)
          report_mismatch($sformatf("sum of column %0d", want.column), out_rsp.sum, want.sum);
        if (out_rsp.saturated !== want.saturated)
          report_mismatch($sformatf("saturated of column %0d", want.column),
                          32'(out_rsp.saturated), 32'(want.saturated));
        if (out_rsp.last !== want.last)
          report_mismatch($sformatf("last of column %0d", want.column),
                          32'(out_rsp.last), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("dense_layer_matrix_multiply_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int      lv;
    int      cv;
    int      n;
    in_req_t r;
    for (int k = 0; k < MAX_COLUMNS; k++) col_acc[k] = '0;
    len_reg       = LEN_RESET;
    cnt_reg       = CNT_RESET;
    elem_pos      = 0;
    send_idle_pct = 27;
    stall_pct     = 79;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan.push_back(cfg_row(CFG_INPUT_LENGTH, 1));
    plan.push_back(cfg_row(CFG_OUTPUT_COUNT, 1));
    plan.push_back(wt_row(0, 0, 16'h0100));
    plan.push_back(chk_row(16'h0100, 32'h0001_0000, 1'b0));
    plan.push_back(wt_row(0, 0, 16'h7fff));
    plan.push_back(chk_row(16'h8000, 32'hc000_8000, 1'b0));
    plan.push_back(wt_row(0, 0, 16'h8000));
    plan.push_back(chk_row(16'h8000, 32'h4000_0000, 1'b0));
    plan.push_back(cfg_row(CFG_INPUT_LENGTH, 3));
    plan.push_back(wt_row(1, 0, 16'h8000));
    plan.push_back(wt_row(2, 0, 16'h8000));
    plan.push_back(dat_row(16'h8000));
    plan.push_back(dat_row(16'h8000));
    plan.push_back(chk_row(16'h8000, 32'h7fff_ffff, 1'b1));
    plan.push_back(wt_row(0, 0, 16'h7fff));
    plan.push_back(wt_row(1, 0, 16'h7fff));
    plan.push_back(wt_row(2, 0, 16'h7fff));
    plan.push_back(dat_row(16'h8000));
    plan.push_back(dat_row(16'h8000));
    plan.push_back(chk_row(16'h8000, 32'h8000_0000, 1'b1));
    plan.push_back(wt_row(63, 15, 16'h7fff));
    plan.push_back(cfg_row(CFG_INPUT_LENGTH, 0));
    plan.push_back(cfg_row(CFG_OUTPUT_COUNT, 31));
    plan.push_back(dat_row(16'h7fff));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else issue(plan[i].req, plan[i].has_sum, plan[i].sum);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 79;
        stall_pct     = 27;
      end
      if (ph == 6) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      lv = (PHASE_LEN[ph] < 0) ? $urandom_range(1, 8) : PHASE_LEN[ph];
      cv = (PHASE_CNT[ph] < 0) ? $urandom_range(0, 31) : PHASE_CNT[ph];
      write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'(lv));
      write_reg(CFG_OUTPUT_COUNT, CFG_DATA_W'(cv));
      // long rows stay open and are closed by the shorter length that follows
      n = (lv >= 32) ? 10 : 18;
      for (int i = 0; i < n; i++) begin
        if ((ph == 2 && i == 10) || $urandom_range(49) == 0) drain_sums();
        r.operation  = ($urandom_range(9) < 7) ? OP_DATA : OP_WEIGHT;
        r.weight_row = 6'($urandom);
        r.weight_col = 4'($urandom);
        r.value      = rand_value();
        issue(r, 1'b0, '0);
      end
    end

    drain_sums();
    if (errors == 0) begin
      $display("dense_layer_matrix_multiply_unit regression: pass");
    end else begin
      $display("dense_layer_matrix_multiply_unit regression: fail");
    end
    $finish;
  end

endmodule
